// File: rtl/grid_min_connect_threshold_defines.svh
// Assertion macros shared by the checker.
`ifndef GRID_MIN_CONNECT_THRESHOLD_DEFINES_SVH
`define GRID_MIN_CONNECT_THRESHOLD_DEFINES_SVH
// Antecedent implies consequent on the next clock.
`define GMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
// Antecedent implies consequent in the same clock.
`define GMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`endif

// File: rtl/gmc_pkg.sv
package gmc_pkg;
  localparam int DEF_MAX_ROWS   = 128;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_VALUE_BITS = 30;
  localparam int CFG_W          = 8;
  localparam int THR_W          = 31;
  localparam logic CFG_IDX_ROWS = 1'b0;
  localparam logic CFG_IDX_COLS = 1'b1;
endpackage

// File: rtl/grid_min_connect_threshold.sv
// Grid minimum-connect threshold.
// Configuration: write cfg_we with cfg_index (0 = rows, 1 = columns) and
// cfg_data while no search runs. A zero size is taken as one and a size
// above the maximum saturates.
// Input: each request (start high while busy is low) carries one cell value,
// in row-major order, and cells stream at one per cycle. The request that
// completes the grid starts the search, and busy stays high until the result
// is out.
// Search: a binary search over 0..2^31-1 with at most 32 probes. Each probe
// clears the visited map but for the start cell, then runs a breadth-first
// flood fill: each dequeued cell is read from the queue, its value fetched,
// and for each of its four directions the neighbor is bounds-checked and,
// when on the grid, addressed, read and compared. A final pass checks the
// visited map cell by cell; all neighbor compares share one compare unit.
// Output: out_valid is high for exactly one cycle with out_min_threshold;
// the receiver cannot stall, so nothing backs up.
// Reset: synchronous active-low rst_n returns to idle with the load count at
// zero and sizes at one. Grid memory contents are not cleared; every cell the
// search reads was written during the current load.
module grid_min_connect_threshold
  import gmc_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [29:0]           in_cell_value,
  output logic                  out_valid,
  output logic [THR_W-1:0]      out_min_threshold
);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = AW + 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int QW    = RW + KW;
  localparam int VW    = (VALUE_BITS < 30) ? VALUE_BITS : 30;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_PROBE = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_DEQ   = 4'd3;
  localparam logic [3:0] S_CUR   = 4'd4;
  localparam logic [3:0] S_NBR   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_CHK2  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_QRD   = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  logic [3:0] state_r;
  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;

  // The queue holds each cell as its packed row and column, so no division
  // is needed to find the neighbors of a dequeued cell.
  logic [VW-1:0] grid_mem [CELLS];
  logic          vis_mem  [CELLS];
  logic [QW-1:0] q_mem    [CELLS];

  logic [CW-1:0] load_cnt_r, head_r, tail_r, idx_r;
  logic [AW-1:0] nidx_r;
  logic [RW-1:0] cur_row_r, nrow_r;
  logic [KW-1:0] cur_col_r, ncol_r;
  logic [1:0]    dir_r;
  logic [31:0]   lo_r, hi_r, mid_r, best_r;
  logic [VW-1:0] cur_val_r, grid_rd_r;
  logic          vis_rd_r;
  logic [QW-1:0] q_rd_r;

  // Clamped sizes.
  logic [RW:0] rows;
  logic [KW:0] cols;
  logic [CW-1:0] total;
  always_comb begin
    if (rows_cfg_r == '0) rows = (RW+1)'(1);
    else if (32'(rows_cfg_r) > MAX_ROWS) rows = (RW+1)'(MAX_ROWS);
    else rows = (RW+1)'(rows_cfg_r);
    if (cols_cfg_r == '0) cols = (KW+1)'(1);
    else if (32'(cols_cfg_r) > MAX_COLS) cols = (KW+1)'(MAX_COLS);
    else cols = (KW+1)'(cols_cfg_r);
  end
  assign total = CW'(rows) * CW'(cols);

  // Linear index of the queue entry at the head.
  logic [AW-1:0] q_idx;
  assign q_idx = AW'(CW'(q_rd_r[QW-1:KW]) * CW'(cols) + CW'(q_rd_r[KW-1:0]));

  // Neighbor coordinates for the current direction.
  logic          nb_in;
  logic [RW-1:0] nb_row;
  logic [KW-1:0] nb_col;
  always_comb begin
    nb_in  = 1'b0;
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    case (dir_r)
      2'd0: begin nb_in = (cur_row_r != '0); nb_row = cur_row_r - 1'b1; end
      2'd1: begin nb_in = ((RW+1)'(cur_row_r) + 1'b1 < rows); nb_row = cur_row_r + 1'b1; end
      2'd2: begin nb_in = (cur_col_r != '0); nb_col = cur_col_r - 1'b1; end
      default: begin
        nb_in = ((KW+1)'(cur_col_r) + 1'b1 < cols); nb_col = cur_col_r + 1'b1;
      end
    endcase
  end

  logic [VW-1:0] diff;
  assign diff = (cur_val_r > grid_rd_r) ? cur_val_r - grid_rd_r : grid_rd_r - cur_val_r;

  logic [AW-1:0] grid_ra, vis_ra;
  logic          grid_we, vis_we, q_we;
  logic [AW-1:0] grid_wa, vis_wa;
  logic          vis_wd;
  logic [VW-1:0] grid_wd;
  logic          accept;
  assign accept = start && !busy;
  assign busy   = (state_r != S_LOAD);

  always_comb begin
    grid_we = accept && (load_cnt_r < CW'(CELLS));
    grid_wa = load_cnt_r[AW-1:0];
    grid_wd = in_cell_value[VW-1:0];
    grid_ra = (state_r == S_DEQ || state_r == S_QRD) ? q_idx : nidx_r;
    vis_ra  = (state_r == S_CHK) ? idx_r[AW-1:0] : nidx_r;
    vis_we  = 1'b0;
    vis_wa  = idx_r[AW-1:0];
    vis_wd  = 1'b0;
    q_we    = 1'b0;
    if (state_r == S_CLR) begin
      vis_we = 1'b1;
      vis_wd = (idx_r == '0);
    end else if (state_r == S_CMP && !vis_rd_r && diff <= VW'(mid_r > 32'(2**VW - 1)
                 ? 32'(2**VW - 1) : mid_r)) begin
      vis_we = 1'b1;
      vis_wa = nidx_r;
      vis_wd = 1'b1;
      q_we   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_wa] <= grid_wd;
    grid_rd_r <= grid_mem[grid_ra];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd_r <= vis_mem[vis_ra];
    if (q_we) q_mem[tail_r[AW-1:0]] <= {nrow_r, ncol_r};
    else if (state_r == S_CLR && idx_r == '0) q_mem[0] <= '0;
    q_rd_r <= q_mem[head_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      rows_cfg_r <= CFG_W'(1);
      cols_cfg_r <= CFG_W'(1);
      load_cnt_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_ROWS) rows_cfg_r <= cfg_data;
        else cols_cfg_r <= cfg_data;
      end
      unique case (state_r)
        S_LOAD: if (accept) begin
          if (load_cnt_r + 1'b1 >= total) begin
            load_cnt_r <= '0;
            lo_r   <= '0;
            hi_r   <= 32'h7FFF_FFFF;
            best_r <= 32'h7FFF_FFFF;
            state_r <= S_PROBE;
          end else begin
            load_cnt_r <= load_cnt_r + 1'b1;
          end
        end
        S_PROBE: begin
          if (lo_r > hi_r) begin
            state_r <= S_DONE;
          end else begin
            mid_r   <= lo_r + ((hi_r - lo_r) >> 1);
            idx_r   <= '0;
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          if (idx_r + 1'b1 >= total) begin
            head_r  <= '0;
            tail_r  <= CW'(1);
            state_r <= S_QRD;
          end
          idx_r <= idx_r + 1'b1;
        end
        S_QRD: state_r <= S_DEQ;
        S_DEQ: begin
          if (head_r >= tail_r) begin
            idx_r    <= '0;
            state_r  <= S_CHK;
          end else begin
            cur_row_r <= q_rd_r[QW-1:KW];
            cur_col_r <= q_rd_r[KW-1:0];
            head_r    <= head_r + 1'b1;
            state_r   <= S_CUR;
          end
        end
        S_CUR: begin
          cur_val_r <= grid_rd_r;
          state_r   <= S_NBR;
          dir_r     <= 2'd0;
        end
        S_NBR: begin
          if (nb_in) begin
            nidx_r  <= AW'(CW'(nb_row) * CW'(cols) + CW'(nb_col));
            nrow_r  <= nb_row;
            ncol_r  <= nb_col;
            state_r <= S_WAIT;
          end else if (dir_r == 2'd3) begin
            state_r <= S_QRD;
          end else begin
            dir_r <= dir_r + 1'b1;
          end
        end
        // The memories are addressed by nidx_r here; their data is ready
        // in the compare cycle that follows.
        S_WAIT: state_r <= S_CMP;
        S_CMP: begin
          if (q_we) tail_r <= tail_r + 1'b1;
          if (dir_r == 2'd3) state_r <= S_QRD;
          else begin
            dir_r   <= dir_r + 1'b1;
            state_r <= S_NBR;
          end
        end
        S_CHK: state_r <= S_CHK2;
        S_CHK2: begin
          if (!vis_rd_r) begin
            lo_r    <= mid_r + 1'b1;
            state_r <= S_PROBE;
          end else if (idx_r + 1'b1 >= total) begin
            best_r <= mid_r;
            if (mid_r == '0) state_r <= S_DONE;
            else begin
              hi_r    <= mid_r - 1'b1;
              state_r <= S_PROBE;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CHK;
          end
        end
        S_DONE: begin
          out_valid         <= 1'b1;
          out_min_threshold <= best_r[THR_W-1:0];
          state_r           <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

// File: rtl/gmc_checker.sv
`include "grid_min_connect_threshold_defines.svh"
module gmc_checker
  import gmc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [THR_W-1:0] out_min_threshold
);
  // A result is a single-cycle strobe.
  `GMC_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid)
  // A result ends the search, so the block is free while it shows.
  `GMC_ASSERT_NOW(a_free_after, out_valid, !busy)
  // An idle block that sees no start raises no result.
  `GMC_ASSERT_NEXT(a_no_spurious, !busy && !start, !out_valid)
  // The result never exceeds the largest threshold.
  `GMC_ASSERT_NOW(a_range, out_valid, out_min_threshold <= {THR_W{1'b1}})
endmodule

bind grid_min_connect_threshold gmc_checker u_gmc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_min_threshold(out_min_threshold)
);
